FILE: rtl/skt_pkg.sv
// Shared types, codes and defaults for the sorted key table.
package skt_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam int KEY_W  = 20;
  localparam int DUR_W  = 19;
  localparam int LANG_W = 14;
  localparam int LET_W  = 8;
  localparam int NUM_W  = 14;
  localparam int STS_W  = 2;
  localparam int POS_W  = 6;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [STS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STS_W-1:0] STATUS_FULL      = 2'd2;

  typedef struct packed {
    logic              op;
    logic [KEY_W-1:0]  key;
    logic [DUR_W-1:0]  duration;
    logic [LANG_W-1:0] language;
    logic [LET_W-1:0]  category_letter;
    logic [NUM_W-1:0]  category_number;
  } in_t;

  typedef struct packed {
    logic [STS_W-1:0]  status;
    logic [POS_W-1:0]  position;
    logic [DUR_W-1:0]  found_duration;
    logic [LANG_W-1:0] found_language;
    logic [LET_W-1:0]  found_letter;
    logic [NUM_W-1:0]  found_number;
  } out_t;

  // one stored record
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [DUR_W-1:0]  duration;
    logic [LANG_W-1:0] language;
    logic [LET_W-1:0]  letter;
    logic [NUM_W-1:0]  number;
  } rec_t;

  typedef enum logic [1:0] {
    EM_INSERT = 2'd0,
    EM_FOUND  = 2'd1,
    EM_MISS   = 2'd2,
    EM_FULL   = 2'd3
  } emit_t;

  typedef struct packed {
    logic  load;
    logic  rd_prev;
    logic  rd_prev2;
    logic  rd_mid;
    logic  shift;
    logic  put;
    logic  go_right;
    logic  go_left;
    logic  emit;
    emit_t emit_kind;
  } cmd_t;

  typedef struct packed {
    logic op_lookup;
    logic full;
    logic slot_zero;
    logic slot_one;
    logic key_lt;
    logic key_eq;
    logic range_empty;
  } sts_t;

endpackage

FILE: rtl/skt_ctrl.sv
// Sequencer for ordered insert and binary-search lookup.
module skt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  skt_pkg::sts_t sts,
  output logic          busy,
  output skt_pkg::cmd_t cmd
);
  import skt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_INS    = 6'b000100,
    S_PUT    = 6'b001000,
    S_SRCH   = 6'b010000,
    S_SCMP   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.op_lookup) begin
          state_nxt = S_SRCH;
        end else if (sts.full) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = EM_FULL;
          state_nxt     = S_IDLE;
        end else if (sts.slot_zero) begin
          cmd.put       = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_kind = EM_INSERT;
          state_nxt     = S_IDLE;
        end else begin
          cmd.rd_prev = 1'b1;
          state_nxt   = S_INS;
        end
      end
      S_INS: begin
        // read data holds the entry just below the current slot
        if (sts.key_lt) begin
          cmd.shift = 1'b1;
          if (sts.slot_one) begin
            state_nxt = S_PUT;
          end else begin
            cmd.rd_prev2 = 1'b1;
          end
        end else begin
          cmd.put       = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_kind = EM_INSERT;
          state_nxt     = S_IDLE;
        end
      end
      S_PUT: begin
        cmd.put       = 1'b1;
        cmd.emit      = 1'b1;
        cmd.emit_kind = EM_INSERT;
        state_nxt     = S_IDLE;
      end
      S_SRCH: begin
        if (sts.range_empty) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = EM_MISS;
          state_nxt     = S_IDLE;
        end else begin
          cmd.rd_mid = 1'b1;
          state_nxt  = S_SCMP;
        end
      end
      S_SCMP: begin
        if (sts.key_eq) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = EM_FOUND;
          state_nxt     = S_IDLE;
        end else begin
          if (sts.key_lt) begin
            cmd.go_left = 1'b1;
          end else begin
            cmd.go_right = 1'b1;
          end
          state_nxt = S_SRCH;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  a_shift_then_read: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.shift && !sts.slot_one) |-> cmd.rd_prev2)
    else $error("shift without follow-on read");

  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (state_r == S_IDLE))
    else $error("emit did not end the item");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !busy)
    else $error("load while busy");

endmodule

FILE: rtl/skt_dpath.sv
// Record memory, search bounds, insert slot and result register.
module skt_dpath #(
  parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  skt_pkg::in_t  in_data,
  input  skt_pkg::cmd_t cmd,
  output skt_pkg::sts_t sts,
  output logic          out_valid,
  output skt_pkg::out_t out_data
);
  import skt_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  rec_t mem [TABLE_DEPTH];

  in_t           item_r;
  rec_t          rd_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] slot_r;
  logic [CW-1:0] lo_r;
  logic [CW-1:0] hi_ex_r;   // exclusive upper bound
  logic [CW-1:0] mid_r;
  logic          out_valid_r;
  out_t          out_r;
  out_t          out_nxt;

  logic [CW:0]     mid_sum;
  logic [CW-1:0]   mid_c;
  logic [CW-1:0]   slot_m1;
  logic [CW-1:0]   slot_m2;
  logic [AW-1:0]   rd_addr;
  logic            rd_en;
  logic            wr_en;
  rec_t            wr_data;
  rec_t            new_rec;
  logic [AW+POS_W-1:0] slot_ext;
  logic [AW+POS_W-1:0] mid_ext;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_ex_r} - (CW+1)'(1);
  assign mid_c   = mid_sum[CW:1];
  assign slot_m1 = slot_r - CW'(1);
  assign slot_m2 = slot_r - CW'(2);

  always_comb begin
    if (cmd.rd_mid) begin
      rd_addr = mid_c[AW-1:0];
    end else if (cmd.rd_prev2) begin
      rd_addr = slot_m2[AW-1:0];
    end else begin
      rd_addr = slot_m1[AW-1:0];
    end
  end

  assign rd_en = cmd.rd_prev | cmd.rd_prev2 | cmd.rd_mid;
  assign wr_en = cmd.shift | cmd.put;

  assign new_rec.key      = item_r.key;
  assign new_rec.duration = item_r.duration;
  assign new_rec.language = item_r.language;
  assign new_rec.letter   = item_r.category_letter;
  assign new_rec.number   = item_r.category_number;
  assign wr_data          = cmd.shift ? rd_r : new_rec;

  // both shift and put target the current slot
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot_r[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.put) begin
      count_r <= count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r  <= in_data;
      slot_r  <= count_r;
      lo_r    <= '0;
      hi_ex_r <= count_r;
    end else begin
      if (cmd.shift) begin
        slot_r <= slot_m1;
      end
      if (cmd.go_right) begin
        lo_r <= mid_r + CW'(1);
      end
      if (cmd.go_left) begin
        hi_ex_r <= mid_r;
      end
    end
    if (cmd.rd_mid) begin
      mid_r <= mid_c;
    end
  end

  assign sts.op_lookup   = (item_r.op == OP_LOOKUP);
  assign sts.full        = (count_r == CW'(TABLE_DEPTH));
  assign sts.slot_zero   = (slot_r == '0);
  assign sts.slot_one    = (slot_r == CW'(1));
  assign sts.key_lt      = (item_r.key < rd_r.key);
  assign sts.key_eq      = (item_r.key == rd_r.key);
  assign sts.range_empty = (lo_r >= hi_ex_r);

  // position carries the low bits of the index
  assign slot_ext = {{POS_W{1'b0}}, slot_r[AW-1:0]};
  assign mid_ext  = {{POS_W{1'b0}}, mid_r[AW-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_comb begin
    out_nxt = '0;
    case (cmd.emit_kind)
      EM_INSERT: begin
        out_nxt.status   = STATUS_OK;
        out_nxt.position = slot_ext[POS_W-1:0];
      end
      EM_FOUND: begin
        out_nxt.status         = STATUS_OK;
        out_nxt.position       = mid_ext[POS_W-1:0];
        out_nxt.found_duration = rd_r.duration;
        out_nxt.found_language = rd_r.language;
        out_nxt.found_letter   = rd_r.letter;
        out_nxt.found_number   = rd_r.number;
      end
      EM_MISS: begin
        out_nxt.status = STATUS_NOT_FOUND;
      end
      default: begin
        out_nxt.status = STATUS_FULL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_put_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.put |-> !sts.full)
    else $error("write into a full table");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held over two cycles");

  a_shift_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift |-> (sts.key_lt && !sts.slot_zero))
    else $error("shift of an entry not above the new key");

endmodule

FILE: rtl/sorted_key_table_insert_search_top.sv
// Top level of the sorted key table: ordered insert and binary-search lookup.
//
//   channel  ports                      beat taken when
//   input    start, busy, in_data       start && !busy at a rising edge
//   result   out_valid, out_data        out_valid high for one cycle
//
// Insert: each stored entry with a larger key moves up one slot, then the
// new record is written into the freed slot; at depth 64 at most 63 entries
// move. The shift walks the record memory one entry a cycle, reading the
// next entry down while writing the current one. Lookup: each probe reads
// the middle entry, then compares keys. A full-table insert answers full.
// Synchronous active-low reset empties the table; memory is not cleared.
// The result is shown for one cycle only; the receiver cannot stall it.
module sorted_key_table_insert_search_top #(
  parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  skt_pkg::in_t  in_data,
  output logic          out_valid,
  output skt_pkg::out_t out_data
);
  import skt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  skt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  skt_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
